@@ sv/md5de_pkg.sv @@
`timescale 1ns / 1ps

package md5de_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic [3:0] byte_index;
        logic       last_byte;
    } out_item_t;

    typedef logic [3:0][31:0] word4_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rnd_stat_t;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    localparam word4_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;

    function automatic logic [31:0] sine_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word schedule, all mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] idx;
        case (r[5:4])
            2'd0:    idx = r[3:0];
            2'd1:    idx = 4'd5 * r[3:0] + 4'd1;
            2'd2:    idx = 4'd3 * r[3:0] + 4'd5;
            default: idx = 4'd7 * r[3:0];
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

@@ sv/md5de_round.sv @@
`timescale 1ns / 1ps

module md5de_round (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  md5de_pkg::word4_t     chain,
    input  logic [31:0]           msg_word,
    output logic [3:0]            msg_idx,
    output md5de_pkg::rnd_stat_t  stat,
    output md5de_pkg::word4_t     work
);

    md5de_pkg::word4_t work_reg, work_next;
    logic [31:0] tmp_reg, tmp_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [31:0] sum;
    logic [63:0] rot_wide;

    assign msg_idx = md5de_pkg::msg_index(rnd_reg);
    assign work    = work_reg;
    assign stat    = '{busy: busy_reg, done: done_reg};

    // each round: first a + K + M, then b + rotl(tmp + F)
    always_comb
    begin
        sum      = tmp_reg + md5de_pkg::round_f(rnd_reg[5:4], work_reg[1], work_reg[2],
                                                work_reg[3]);
        rot_wide = {sum, sum} << md5de_pkg::rot_amt(rnd_reg);

        work_next  = work_reg;
        tmp_next   = tmp_reg;
        rnd_next   = rnd_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start)
        begin
            work_next  = chain;
            rnd_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                tmp_next   = work_reg[0] + md5de_pkg::sine_k(rnd_reg) + msg_word;
                phase_next = 1'b1;
            end
            else
            begin
                work_next[0] = work_reg[3];
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[1] + rot_wide[63:32];
                phase_next   = 1'b0;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg   <= '0;
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rnd_reg   <= rnd_next;
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        tmp_reg  <= tmp_next;
    end

endmodule

@@ sv/md5_digest_engine_top.sv @@
`timescale 1ns / 1ps

// MD5 digest engine. A data transaction (func 0) stores one byte; the 64th byte of a
// block also starts the 64 rounds, which run through one shared round unit and are
// then folded into the chaining values, with the input not ready meanwhile. An end
// transaction pads one byte per cycle (up to 72 bytes, with one or two blocks of
// rounds in between) and then presents the 16 digest bytes as 16 output
// transactions, byte 0 first, before the next input is taken.

module md5_digest_engine_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  md5de_pkg::in_item_t   item,
    output logic                  digest_valid,
    input  logic                  digest_ready,
    output md5de_pkg::out_item_t  digest
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_HASH = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    md5de_pkg::word4_t chain_reg, chain_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  fill_reg, fill_next;
    logic        pad_reg, pad_next;
    logic        marker_reg, marker_next;
    logic [3:0]  len_cnt_reg, len_cnt_next;
    logic [3:0]  out_idx_reg, out_idx_next;
    logic [31:0] blk_reg [16];

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        rnd_start;
    logic [3:0]  msg_idx;
    logic [63:0] len_bits;
    logic        zero_pad;
    md5de_pkg::rnd_stat_t rnd_stat;
    md5de_pkg::word4_t    rnd_work;

    md5de_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rnd_start),
        .chain    (chain_reg),
        .msg_word (blk_reg[msg_idx]),
        .msg_idx  (msg_idx),
        .stat     (rnd_stat),
        .work     (rnd_work)
    );

    assign item_ready   = (state_reg == ST_IDLE) && !rnd_stat.busy;
    assign digest_valid = (state_reg == ST_OUT);
    assign digest.digest_byte = chain_reg[out_idx_reg[3:2]][{out_idx_reg[1:0], 3'b000} +: 8];
    assign digest.byte_index  = out_idx_reg;
    assign digest.last_byte   = (out_idx_reg == 4'd15);

    assign len_bits = {count_reg, 3'b000};
    assign zero_pad = (len_cnt_reg == 4'd0) && (fill_reg != md5de_pkg::LEN_POS);

    always_comb
    begin
        state_next   = state_reg;
        chain_next   = chain_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        pad_next     = pad_reg;
        marker_next  = marker_reg;
        len_cnt_next = len_cnt_reg;
        out_idx_next = out_idx_reg;
        wr_en        = 1'b0;
        wr_byte      = item.data_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    if (item.func == md5de_pkg::FUNC_DATA)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 61'd1;
                    end
                    else
                    begin
                        pad_next    = 1'b1;
                        marker_next = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                wr_en = 1'b1;
                if (marker_reg)
                begin
                    wr_byte     = md5de_pkg::PAD_MARKER;
                    marker_next = 1'b0;
                end
                else if (zero_pad)
                begin
                    wr_byte = 8'h00;
                end
                else
                begin
                    wr_byte      = len_bits[{len_cnt_reg[2:0], 3'b000} +: 8];
                    len_cnt_next = len_cnt_reg + 4'd1;
                end
            end
            ST_HASH:
            begin
                if (rnd_stat.done)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        chain_next[i] = chain_reg[i] + rnd_work[i];
                    end
                    if (!pad_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (len_cnt_reg == 4'd8)
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_OUT:
            begin
                if (digest_ready)
                begin
                    out_idx_next = out_idx_reg + 4'd1;
                    if (out_idx_reg == 4'd15)
                    begin
                        chain_next   = md5de_pkg::CHAIN_INIT;
                        count_next   = '0;
                        fill_next    = '0;
                        pad_next     = 1'b0;
                        len_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // block full: run the rounds
        rnd_start = wr_en && (fill_reg == 6'd63);
        if (wr_en)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (rnd_start)
        begin
            state_next = ST_HASH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            chain_reg   <= md5de_pkg::CHAIN_INIT;
            count_reg   <= '0;
            fill_reg    <= '0;
            pad_reg     <= 1'b0;
            marker_reg  <= 1'b0;
            len_cnt_reg <= '0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            chain_reg   <= chain_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            pad_reg     <= pad_next;
            marker_reg  <= marker_next;
            len_cnt_reg <= len_cnt_next;
            out_idx_reg <= out_idx_next;
        end
    end

    // every byte of a block is written before its rounds run, so no reset needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

endmodule

@@ sv/md5de_checker.sv @@
`timescale 1ns / 1ps

module md5de_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input md5de_pkg::in_item_t   item,
    input logic                  digest_valid,
    input logic                  digest_ready,
    input md5de_pkg::out_item_t  digest
);

    // output held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("digest transaction dropped or changed while stalled");

    // one message at a time: no input taken while digest bytes are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && digest_valid))
        else $error("input ready while digest pending");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest.last_byte |=>
            digest_valid && (digest.byte_index == $past(digest.byte_index) + 4'd1))
        else $error("digest bytes not consecutive");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_byte == (digest.byte_index == 4'd15)))
        else $error("last_byte mismatch");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && digest.last_byte |=> item_ready && !digest_valid)
        else $error("engine not re-armed after digest");

endmodule

bind md5_digest_engine_top md5de_checker u_md5de_checker (.*);
